// ===== rtl/bkm_pkg.sv =====
// Shared types and constants for the blocklist keyword matcher.
// Used by the front end, the command queue and the match engine; no dependencies.
`default_nettype none

package bkm_pkg;

    // Input field widths.
    localparam int FUNC_W = 2;
    localparam int CHAR_W = 8;
    localparam int SLOT_W = 4;
    localparam int POS_W  = 5;

    // Packed stream widths, padded to whole bytes.
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 8;

    // Function codes carried on the input tuser.
    localparam logic [FUNC_W-1:0] FUNC_TEXT  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    // Classified command kinds that travel through the queue.
    typedef enum logic [1:0] {
        CMD_TEXT,
        CMD_WRITE,
        CMD_CLEAR
    } cmd_kind_t;

    // One classified request: byte already case-folded.
    typedef struct packed {
        cmd_kind_t          kind;
        logic [CHAR_W-1:0]  ch;
        logic [SLOT_W-1:0]  slot;
        logic [POS_W-1:0]   position;
        logic               last;
    } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/blocklist_keyword_matcher_top.sv =====
// Top level of the blocklist keyword matcher: front end, command queue and
// match engine. Depends on bkm_pkg, bkm_front, bkm_queue and bkm_back.
`default_nettype none

// Case-insensitive keyword matcher. Keyword bytes are loaded one request at a
// time (tuser = write) into SLOTS slots of up to MAX_LEN bytes, a clear
// request empties the table, and text bytes (tuser = text) are matched
// against all non-empty slots at once. The request with tlast on a text byte
// ends the text and produces one result: allowed, the lowest matching slot
// and whether any keyword is loaded. The block takes one request every clock
// cycle while the queue has room; each text byte is compared against all stored
// keyword bytes at once in the match engine. A result passes through a queue
// entry and then the output register once its last text byte is accepted.
// A held result stalls the engine only when the next result is due; the
// two-entry queue keeps taking requests meanwhile until it is full.
module blocklist_keyword_matcher_top #(
    parameter int SLOTS   = 16,
    parameter int MAX_LEN = 32
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // char_code[7:0], slot[11:8], position[16:12], zero padding
    input  wire logic [bkm_pkg::IN_TDATA_W-1:0]     s_tdata,
    // func[1:0]
    input  wire logic [bkm_pkg::FUNC_W-1:0]         s_tuser,
    input  wire logic                               s_tlast,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // allowed[0], matched_slot[4:1], enabled[5], zero padding
    output logic [bkm_pkg::OUT_TDATA_W-1:0]         m_tdata
);
    import bkm_pkg::*;

    logic  push;
    logic  push_ready;
    cmd_t  push_cmd;
    logic  pop;
    logic  pop_valid;
    cmd_t  pop_cmd;

    // Accept and classify requests.
    bkm_front #(
        .SLOTS   (SLOTS),
        .MAX_LEN (MAX_LEN)
    ) u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .func      (s_tuser),
        .char_code (s_tdata[7:0]),
        .slot      (s_tdata[11:8]),
        .position  (s_tdata[16:12]),
        .last      (s_tlast),
        .q_ready   (push_ready),
        .q_push    (push),
        .q_cmd     (push_cmd)
    );

    // Decouple the front end from the match engine.
    bkm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_cmd    (pop_cmd)
    );

    // Run the keyword table and produce results.
    bkm_back #(
        .SLOTS   (SLOTS),
        .MAX_LEN (MAX_LEN)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (pop_valid),
        .q_cmd    (pop_cmd),
        .q_pop    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

// ===== rtl/bkm_front.sv =====
// Front end of the keyword matcher: accepts requests, folds the byte to
// lower case and drops requests that do nothing. Depends on bkm_pkg.
`default_nettype none

module bkm_front #(
    parameter int SLOTS   = 16,
    parameter int MAX_LEN = 32
) (
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [bkm_pkg::FUNC_W-1:0] func,
    input  wire logic [bkm_pkg::CHAR_W-1:0] char_code,
    input  wire logic [bkm_pkg::SLOT_W-1:0] slot,
    input  wire logic [bkm_pkg::POS_W-1:0]  position,
    input  wire logic                       last,
    input  wire logic                       q_ready,
    output logic                            q_push,
    output bkm_pkg::cmd_t                   q_cmd
);
    import bkm_pkg::*;

    logic              in_range;
    logic              keep;
    logic [CHAR_W-1:0] folded;

    // Fold A-Z to a-z.
    always_comb
    begin
        if (char_code >= 8'h41 && char_code <= 8'h5A)
        begin
            folded = char_code + 8'h20;
        end
        else
        begin
            folded = char_code;
        end
    end

    // A keyword byte outside the table is ignored.
    assign in_range = (int'(slot) < SLOTS) && (int'(position) < MAX_LEN);

    // Classify the request into a queue command.
    always_comb
    begin
        q_cmd.ch       = folded;
        q_cmd.slot     = slot;
        q_cmd.position = position;
        q_cmd.last     = last;
        q_cmd.kind     = CMD_TEXT;
        keep           = 1'b0;
        case (func)
            FUNC_TEXT:
            begin
                q_cmd.kind = CMD_TEXT;
                keep       = 1'b1;
            end
            FUNC_WRITE:
            begin
                q_cmd.kind = CMD_WRITE;
                keep       = in_range;
            end
            FUNC_CLEAR:
            begin
                q_cmd.kind = CMD_CLEAR;
                keep       = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign s_tready = q_ready;
    assign q_push   = s_tvalid && q_ready && keep;

endmodule

`default_nettype wire

// ===== rtl/bkm_queue.sv =====
// Two-entry command queue between the front end and the match engine.
// Depends on bkm_pkg for the command type.
`default_nettype none

module bkm_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire bkm_pkg::cmd_t push_cmd,
    output logic               push_ready,
    input  wire logic          pop,
    output logic               pop_valid,
    output bkm_pkg::cmd_t      pop_cmd
);
    import bkm_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_pop     = pop && pop_valid;

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (!push && do_pop)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bkm_back.sv =====
// Match engine of the keyword matcher: keyword table, per-slot shift-and
// progress, found flags and the result register. Depends on bkm_pkg.
`default_nettype none

module bkm_back #(
    parameter int SLOTS   = 16,
    parameter int MAX_LEN = 32
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            q_valid,
    input  wire bkm_pkg::cmd_t                   q_cmd,
    output logic                                 q_pop,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [bkm_pkg::OUT_TDATA_W-1:0]      m_tdata
);
    import bkm_pkg::*;

    localparam int LEN_W = $clog2(MAX_LEN + 1);

    logic [CHAR_W-1:0]      kw_reg    [SLOTS][MAX_LEN];
    logic [LEN_W-1:0]       len_reg   [SLOTS];
    logic [MAX_LEN-1:0]     prog_reg  [SLOTS];
    logic [SLOTS-1:0]       found_reg;
    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    logic [MAX_LEN-1:0]     eq_vec    [SLOTS];
    logic [MAX_LEN-1:0]     top_vec   [SLOTS];
    logic [MAX_LEN-1:0]     adv_prog  [SLOTS];
    logic [SLOTS-1:0]       hit_vec;
    logic [SLOTS-1:0]       found_next;
    logic                   enabled;
    logic                   blocked;
    logic [SLOT_W-1:0]      first_hit;
    logic                   is_result;
    logic                   out_free;

    // Compare the text byte against every stored keyword byte in parallel.
    always_comb
    begin
        for (int s = 0; s < SLOTS; s++)
        begin
            for (int i = 0; i < MAX_LEN; i++)
            begin
                eq_vec[s][i]  = (kw_reg[s][i] == q_cmd.ch) && (i < int'(len_reg[s]));
                top_vec[s][i] = (i == int'(len_reg[s]) - 1);
            end
            adv_prog[s] = ((prog_reg[s] << 1) | MAX_LEN'(1)) & eq_vec[s];
            hit_vec[s]  = (len_reg[s] != '0) && (|(adv_prog[s] & top_vec[s]));
        end
    end

    // Result: table state and lowest found slot after this byte.
    always_comb
    begin
        found_next = found_reg | hit_vec;
        enabled    = 1'b0;
        first_hit  = '0;
        for (int s = 0; s < SLOTS; s++)
        begin
            if (len_reg[s] != '0)
            begin
                enabled = 1'b1;
            end
        end
        for (int s = SLOTS - 1; s >= 0; s--)
        begin
            if (found_next[s])
            begin
                first_hit = SLOT_W'(s);
            end
        end
        blocked = enabled && (|found_next);
        if (!blocked)
        begin
            first_hit = '0;
        end
    end

    // A last text byte needs room in the output register.
    assign is_result = (q_cmd.kind == CMD_TEXT) && q_cmd.last;
    assign out_free  = !out_valid_reg || m_tready;
    assign q_pop     = q_valid && (!is_result || out_free);

    // Keyword byte storage.
    always_ff @(posedge clk)
    begin
        if (q_pop && q_cmd.kind == CMD_WRITE)
        begin
            for (int s = 0; s < SLOTS; s++)
            begin
                for (int i = 0; i < MAX_LEN; i++)
                begin
                    if (int'(q_cmd.slot) == s && int'(q_cmd.position) == i)
                    begin
                        kw_reg[s][i] <= q_cmd.ch;
                    end
                end
            end
        end
    end

    // Lengths, progress vectors and found flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SLOTS; s++)
            begin
                len_reg[s]  <= '0;
                prog_reg[s] <= '0;
            end
            found_reg <= '0;
        end
        else if (q_pop)
        begin
            case (q_cmd.kind)
                CMD_TEXT:
                begin
                    if (q_cmd.last)
                    begin
                        for (int s = 0; s < SLOTS; s++)
                        begin
                            prog_reg[s] <= '0;
                        end
                        found_reg <= '0;
                    end
                    else
                    begin
                        for (int s = 0; s < SLOTS; s++)
                        begin
                            if (len_reg[s] != '0)
                            begin
                                prog_reg[s] <= adv_prog[s];
                            end
                        end
                        found_reg <= found_next;
                    end
                end
                CMD_WRITE:
                begin
                    for (int s = 0; s < SLOTS; s++)
                    begin
                        if (int'(q_cmd.slot) == s)
                        begin
                            if (q_cmd.last)
                            begin
                                len_reg[s] <= LEN_W'(int'(q_cmd.position) + 1);
                            end
                            prog_reg[s]  <= '0;
                            found_reg[s] <= 1'b0;
                        end
                    end
                end
                CMD_CLEAR:
                begin
                    for (int s = 0; s < SLOTS; s++)
                    begin
                        len_reg[s]  <= '0;
                        prog_reg[s] <= '0;
                    end
                    found_reg <= '0;
                end
                default:
                begin
                    found_reg <= found_reg;
                end
            endcase
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (q_pop && is_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload: allowed, matched slot, enabled.
    always_ff @(posedge clk)
    begin
        if (q_pop && is_result)
        begin
            out_data_reg <= {2'b00, enabled, first_hit, !blocked};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

// ===== test/blocklist_keyword_matcher_top_tb.sv =====
// Self-checking testbench for blocklist_keyword_matcher_top: loads keyword tables,
// streams texts under random valid/ready gaps and checks every verdict.
// Depends on bkm_pkg and the RTL under rtl/.
`default_nettype none

module blocklist_keyword_matcher_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bkm_pkg::*;

    localparam int SLOTS       = 16;
    localparam int MAX_LEN     = 32;
    localparam int RAND_ITEMS  = 800;
    localparam int HOLD_CYCLES = 150;
    localparam int CYCLE_LIMIT = 200000;

    // The fourth function code is unused by the block and must be ignored.
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    typedef struct {
        bit       allowed;
        bit [3:0] slot;
        bit       enabled;
    } verdict_t;

    // Tracks the keyword table and per-slot match progress, and holds the
    // verdicts that texts still owe.
    class verdict_scoreboard;
        logic [7:0]  kw_byte  [SLOTS][MAX_LEN];
        logic [5:0]  kw_len   [SLOTS];
        logic [31:0] progress [SLOTS];
        logic [15:0] found;
        verdict_t    pending_verdicts[$];
        int          errors;
        int          checked;
        int          blocked;

        function new();
            foreach (kw_len[s])
            begin
                kw_len[s]   = '0;
                progress[s] = '0;
            end
            found   = '0;
            errors  = 0;
            checked = 0;
            blocked = 0;
        endfunction

        // Apply one accepted request to the table and queue any verdict it owes.
        function void note_request(logic [1:0] func, logic [7:0] code, logic [3:0] slot,
                                   logic [4:0] pos, logic last);
            logic [7:0]  c;
            logic [31:0] hits;
            verdict_t    v;
            c = (code >= 8'h41 && code <= 8'h5A) ? code + 8'h20 : code;
            case (func)
                FUNC_WRITE:
                begin
                    kw_byte[slot][pos] = c;
                    if (last)
                        kw_len[slot] = {1'b0, pos} + 6'd1;
                    progress[slot] = '0;
                    found[slot]    = 1'b0;
                end
                FUNC_CLEAR:
                begin
                    foreach (kw_len[s])
                    begin
                        kw_len[s]   = '0;
                        progress[s] = '0;
                    end
                    found = '0;
                end
                FUNC_TEXT:
                begin
                    // Shift-and step for every loaded slot.
                    foreach (kw_len[s])
                    begin
                        if (kw_len[s] != 0)
                        begin
                            hits = '0;
                            for (int i = 0; i < kw_len[s]; i++)
                                hits[i] = (kw_byte[s][i] == c);
                            progress[s] = ((progress[s] << 1) | 32'd1) & hits;
                            if (progress[s][kw_len[s] - 1])
                                found[s] = 1'b1;
                        end
                    end
                    if (last)
                    begin
                        v.enabled = 1'b0;
                        v.allowed = 1'b1;
                        v.slot    = '0;
                        foreach (kw_len[s])
                            if (kw_len[s] != 0)
                                v.enabled = 1'b1;
                        // Walk downward so the lowest found slot wins.
                        if (v.enabled)
                            for (int s = SLOTS - 1; s >= 0; s--)
                                if (found[s])
                                begin
                                    v.allowed = 1'b0;
                                    v.slot    = s[3:0];
                                end
                        pending_verdicts = {pending_verdicts, v};
                        foreach (progress[s])
                            progress[s] = '0;
                        found = '0;
                    end
                end
                default:
                    ;
            endcase
        endfunction

        // Compare one output verdict with the oldest one owed.
        function void check_verdict(logic [7:0] data);
            verdict_t v;
            if (pending_verdicts.size() == 0)
            begin
                $error("verdict with no text pending: tdata=%h", data);
                errors++;
                return;
            end
            v = pending_verdicts.pop_front();
            checked++;
            if (!v.allowed)
                blocked++;
            if (data[0] !== v.allowed)
            begin
                $error("allowed: expected %0d, got %0d", v.allowed, data[0]);
                errors++;
            end
            if (data[4:1] !== v.slot)
            begin
                $error("matched_slot: expected %0d, got %0d", v.slot, data[4:1]);
                errors++;
            end
            if (data[5] !== v.enabled)
            begin
                $error("enabled: expected %0d, got %0d", v.enabled, data[5]);
                errors++;
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_TDATA_W-1:0] s_tdata = '0;
    logic [FUNC_W-1:0]     s_tuser = '0;
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    verdict_scoreboard sb = new();

    logic [31:0] kw_written [SLOTS];
    int          sent_count = 0;
    int          loads = 0;
    int          clears = 0;
    int          cycles = 0;
    int          sink_idle = 0;
    bit          gapless = 1'b0;
    bit          steady = 1'b0;
    bit          hold_req = 1'b0;

    blocklist_keyword_matcher_top #(
        .SLOTS   (SLOTS),
        .MAX_LEN (MAX_LEN)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Output monitor.
    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.check_verdict(m_tdata);

    // Output ready: random stalls, quiet stretches and one long hold-off.
    initial
    begin : sink_ready
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            else if (sink_idle > 0)
            begin
                m_tready <= 1'b0;
                sink_idle--;
            end
            else if (!steady && $urandom_range(0, 99) < 20)
            begin
                m_tready <= 1'b0;
                sink_idle = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 2)
                                                          : $urandom_range(10, 40);
            end
            else
                m_tready <= 1'b1;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (gapless || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 8);
        return $urandom_range(15, 40);
    endfunction

    // Mostly a small mixed-case alphabet so keywords really occur in texts,
    // plus bytes around the folding range and fully random bytes.
    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 8'($urandom_range(0, 3)) + ($urandom_range(0, 1) ? 8'h41 : 8'h61);
        if (r < 80)
        begin
            case ($urandom_range(0, 5))
                0: return 8'h40;
                1: return 8'h5A;
                2: return 8'h5B;
                3: return 8'h60;
                4: return 8'h7A;
                default: return 8'h7B;
            endcase
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // A keyword length may only cover positions that have been written.
    function automatic bit prefix_written(logic [3:0] slot, logic [4:0] pos);
        logic [31:0] mask;
        mask = (32'd1 << pos) - 32'd1;
        return (kw_written[slot] & mask) == mask;
    endfunction

    // Offer one request from a falling edge and return at the falling edge
    // after it is accepted.
    task automatic offer_request(logic [1:0] func, logic [7:0] code, logic [3:0] slot,
                                 logic [4:0] pos, logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, pos, slot, code};
        s_tuser  <= func;
        s_tlast  <= last;
        if (func == FUNC_WRITE)
            kw_written[slot][pos] = 1'b1;
        if (func != FUNC_UNUSED)
            sent_count++;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(func, code, slot, pos, last);
        @(negedge clk);
    endtask

    task automatic load_keyword(logic [3:0] slot, int len);
        for (int p = 0; p < len; p++)
            offer_request(FUNC_WRITE, pick_char(), slot, p[4:0], p == len - 1);
        loads++;
    endtask

    // A random text; now and then a keyword byte lands in the middle of it.
    task automatic send_text(int len);
        logic [3:0] s;
        logic [4:0] p;
        for (int k = 0; k < len; k++)
        begin
            if (k > 0 && $urandom_range(0, 99) < 5)
            begin
                s = 4'($urandom_range(0, SLOTS - 1));
                p = 5'($urandom_range(0, 3));
                offer_request(FUNC_WRITE, pick_char(), s, p,
                              $urandom_range(0, 1) && prefix_written(s, p));
            end
            offer_request(FUNC_TEXT, pick_char(), '0, '0, k == len - 1);
        end
    endtask

    initial
    begin : stimulus
        int         r;
        int         len;
        logic [3:0] s;
        logic [4:0] p;
        bit         pressed;
        pressed = 1'b0;
        foreach (kw_written[i])
            kw_written[i] = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // Text against an empty table, and an unused function code.
        offer_request(FUNC_TEXT, 8'h78, 4'd0, 5'd0, 1'b1);
        offer_request(FUNC_UNUSED, 8'hFF, 4'hF, 5'h1F, 1'b1);
        // Keywords "ab" in slot 5 and "b" in slot 9, loaded partly in upper case.
        offer_request(FUNC_WRITE, 8'h41, 4'd5, 5'd0, 1'b0);
        offer_request(FUNC_WRITE, 8'h62, 4'd5, 5'd1, 1'b1);
        offer_request(FUNC_WRITE, 8'h42, 4'd9, 5'd0, 1'b1);
        // Both occur; the lower slot is reported.
        offer_request(FUNC_TEXT, 8'h61, 4'd0, 5'd0, 1'b0);
        offer_request(FUNC_TEXT, 8'h42, 4'd0, 5'd0, 1'b1);
        // Rewriting slot 5 mid-text drops its progress, so only slot 9 hits.
        offer_request(FUNC_TEXT, 8'h61, 4'd0, 5'd0, 1'b0);
        offer_request(FUNC_WRITE, 8'h42, 4'd5, 5'd1, 1'b1);
        offer_request(FUNC_TEXT, 8'h62, 4'd0, 5'd0, 1'b1);
        // No keyword in the text.
        offer_request(FUNC_TEXT, 8'h5A, 4'd0, 5'd0, 1'b1);
        // Extreme byte value in slot 0.
        offer_request(FUNC_WRITE, 8'hFF, 4'd0, 5'd0, 1'b1);
        offer_request(FUNC_TEXT, 8'hFF, 4'd0, 5'd0, 1'b1);
        // Clearing the table makes every text pass again.
        offer_request(FUNC_CLEAR, 8'h00, 4'd0, 5'd0, 1'b0);
        clears++;
        offer_request(FUNC_TEXT, 8'h61, 4'd0, 5'd0, 1'b1);

        // Random part: mostly keyword loads and texts, some noise.
        sent_count = 0;
        while (sent_count < RAND_ITEMS)
        begin
            steady  = (sent_count >= 300 && sent_count < 420);
            gapless = steady;
            r = $urandom_range(0, 99);
            if (!pressed && sent_count >= 500)
            begin
                // Hold the output off while short texts keep arriving.
                pressed  = 1'b1;
                hold_req = 1'b1;
                gapless  = 1'b1;
                repeat (24)
                    offer_request(FUNC_TEXT, pick_char(), '0, '0, 1'b1);
                gapless = 1'b0;
            end
            else if (r < 3)
            begin
                offer_request(FUNC_CLEAR, pick_char(), 4'($urandom_range(0, 15)),
                              5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
                clears++;
            end
            else if (r < 30)
            begin
                r = $urandom_range(0, 99);
                len = (r < 80) ? $urandom_range(1, 4) :
                      (r < 95) ? $urandom_range(5, 10) : $urandom_range(11, MAX_LEN);
                load_keyword(4'($urandom_range(0, SLOTS - 1)), len);
            end
            else if (r < 38)
            begin
                s = 4'($urandom_range(0, SLOTS - 1));
                p = 5'($urandom_range(0, MAX_LEN - 1));
                case ($urandom_range(0, 2))
                    0: offer_request(FUNC_UNUSED, 8'($urandom_range(0, 255)), s, p,
                                     1'($urandom_range(0, 1)));
                    1: offer_request(FUNC_WRITE, pick_char(), s, p,
                                     $urandom_range(0, 1) && prefix_written(s, p));
                    default: offer_request(FUNC_TEXT, 8'($urandom_range(0, 255)), s, p, 1'b0);
                endcase
            end
            else
                send_text(($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                      : $urandom_range(1, 12));
        end
        steady  = 1'b0;
        gapless = 1'b0;
        s_tvalid <= 1'b0;

        // Drain the pending verdicts, then wait for anything stray.
        while (sb.pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Streamed %0d requests with %0d keyword loads and %0d table clears,",
                 sent_count, loads, clears);
        $display("including a long output hold-off; %0d verdicts checked, %0d blocked.",
                 sb.checked, sb.blocked);
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
